// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/bbc_pkg.sv -----
// Package: constants and command/status types for the binomial bound check
`default_nettype none
package bbc_pkg;
  localparam int unsigned WordBits = 64;

  // Datapath commands issued by the controller
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_PRE     = 4'd2;
  localparam logic [3:0] CMD_DIVQ    = 4'd3;
  localparam logic [3:0] CMD_CHKOV   = 4'd4;
  localparam logic [3:0] CMD_MULACC  = 4'd5;
  localparam logic [3:0] CMD_DIVACC  = 4'd6;
  localparam logic [3:0] CMD_GCDINIT = 4'd7;
  localparam logic [3:0] CMD_GCDMOD  = 4'd8;
  localparam logic [3:0] CMD_RED1    = 4'd9;
  localparam logic [3:0] CMD_RED2    = 4'd10;
  localparam logic [3:0] CMD_RED3    = 4'd11;
  localparam logic [3:0] CMD_MULNP   = 4'd12;
  localparam logic [3:0] CMD_STEPEND = 4'd13;
  localparam logic [3:0] CMD_MULLO   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic       div_start;
  } bbc_cmd_t;

  typedef struct packed {
    logic k_gt_n;
    logic k_zero;
    logic bound_zero;
    logic ovf;
    logic gcd_done;
    logic red_fail;
    logic over;
    logic last;
    logic div_busy;
    logic mul_busy;
  } bbc_stat_t;
endpackage
`default_nettype wire

// ----- rtl/binomial_bound_check_top.sv -----
// Top level of the binomial bound check
// Usage:
//   Input channel: n_total_i, k_chosen_i, limit_value_i with in_valid_i and
//   in_stall_o; a transaction occurs when valid is high and stall is low.
//   Output channel: exceeds_o with out_valid_o and out_stall_i.
//   One query at a time. Trivial queries (k above n, or k zero after
//   symmetry) skip the step loop. Otherwise each loop step for
//   j = 1..min(k,n-k) runs two divides on the bit-serial divider plus a
//   partial-product multiply. A step whose product would overflow first
//   reduces by a Euclid gcd, one divide per iteration, then multiplies.
//   The loop stops early when the running value passes the bound, so a
//   query ends after at most a few dozen steps.
//   The result is held in an output register; a new query can be taken
//   as the last result is taken by the receiver.
//   Reset clears the controller and output valid; no result is pending.
//   While the receiver stalls, the result holds and no new query enters
//   the calculation.
`default_nettype none
module binomial_bound_check_top import bbc_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [WORD_BITS-1:0] n_total_i,
  input  wire logic [WORD_BITS-1:0] k_chosen_i,
  input  wire logic [WORD_BITS-1:0] limit_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      exceeds_o
);
  bbc_cmd_t  cmd;
  bbc_stat_t stat;

  bbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .exceeds_o, .cmd_o(cmd), .stat_i(stat)
  );

  bbc_datapath #(.W(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .n_i(n_total_i), .k_i(k_chosen_i), .b_i(limit_value_i),
    .cmd_i(cmd), .stat_o(stat)
  );
endmodule
`default_nettype wire

// ----- rtl/bbc_div.sv -----
// Restoring divider: one quotient bit per cycle
`default_nettype none
module bbc_div import bbc_pkg::*; #(
  parameter int unsigned W = WordBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              busy_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d, r_q, r_d, d_q, d_d;
  logic [W:0]    sh;
  logic [W:0]    sub;

  always_comb begin
    cnt_d = cnt_q;
    q_d = q_q;
    r_d = r_q;
    d_d = d_q;
    sh = {r_q, q_q[W-1]};
    sub = sh - {1'b0, d_q};
    if (start_i) begin
      cnt_d = CW'(W);
      q_d = num_i;
      r_d = '0;
      d_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!sub[W]) begin
        r_d = sub[W-1:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = sh[W-1:0];
        q_d = {q_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o = q_q;
  assign rem_o = r_q;
endmodule
`default_nettype wire

// ----- rtl/bbc_datapath.sv -----
// Datapath: operand registers, shared divider, 32x32 partial-product multiplier
`default_nettype none
module bbc_datapath import bbc_pkg::*; #(
  parameter int unsigned W = WordBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [W-1:0] n_i,
  input  wire logic [W-1:0] k_i,
  input  wire logic [W-1:0] b_i,
  input  wire bbc_cmd_t     cmd_i,
  output bbc_stat_t         stat_o
);
  localparam int unsigned H = (W + 1) / 2;
  localparam int unsigned HW = 2 * H;

  logic [W-1:0] n_q, k_q, b_q, acc_q, cur_q, j_q, q_q, x_q, y_q, jr_q, np_q;
  logic [W-1:0] n_d, k_d, b_d, acc_d, cur_d, j_d, q_d, x_d, y_d, jr_d, np_d;
  logic         ovf_q, ovf_d, over_q, over_d, fail_q, fail_d;
  logic [W-1:0] dnum, dden, dquo, drem;
  logic         dbusy;
  logic [W-1:0] nk;
  logic [W-1:0] mul_a, mul_b;

  // Partial-product multiplier: four H x H products accumulated in turn
  logic [1:0]       mph_q, mph_d;
  logic             mbusy_q, mbusy_d;
  logic [2*HW-1:0]  prod_q, prod_d;
  logic [HW-1:0]    ma, mb;
  logic [H-1:0]     pa, pb;
  logic [2*H-1:0]   pp;

  bbc_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(dnum), .den_i(dden),
    .busy_o(dbusy), .quo_o(dquo), .rem_o(drem)
  );

  assign nk = n_q - k_q;

  // Divider operand selection by command
  always_comb begin
    dnum = '1 >> 0;
    dden = cur_q;
    case (cmd_i.op)
      CMD_DIVACC:  begin dnum = prod_q[W-1:0]; dden = j_q; end
      CMD_GCDMOD:  begin dnum = x_q; dden = y_q; end
      CMD_RED1:    begin dnum = j_q; dden = x_q; end
      CMD_RED2:    begin dnum = cur_q; dden = jr_q; end
      CMD_RED3:    begin dnum = acc_q; dden = x_q; end
      CMD_MULNP:   begin dnum = '1; dden = acc_q; end
      default:     begin dnum = '1; dden = cur_q; end
    endcase
  end

  // Overflow steps multiply by the reduced factor, ordinary steps by cur
  assign mul_a = acc_q;
  assign mul_b = ovf_q ? np_q : cur_q;
  assign ma = HW'(mul_a);
  assign mb = HW'(mul_b);
  assign pa = mph_q[0] ? ma[HW-1:H] : ma[H-1:0];
  assign pb = mph_q[1] ? mb[HW-1:H] : mb[H-1:0];
  assign pp = pa * pb;

  always_comb begin
    mph_d = mph_q;
    mbusy_d = mbusy_q;
    prod_d = prod_q;
    if (cmd_i.op == CMD_MULLO && !mbusy_q) begin
      mbusy_d = 1'b1;
      mph_d = 2'd0;
      prod_d = '0;
    end else if (mbusy_q) begin
      prod_d = prod_q + ((2*HW)'(pp) << (H * (32'(mph_q[0]) + 32'(mph_q[1]))));
      mph_d = mph_q + 2'd1;
      if (mph_q == 2'd3) mbusy_d = 1'b0;
    end
  end

  always_comb begin
    n_d = n_q; k_d = k_q; b_d = b_q; acc_d = acc_q; cur_d = cur_q; j_d = j_q;
    q_d = q_q; x_d = x_q; y_d = y_q; jr_d = jr_q; np_d = np_q;
    ovf_d = ovf_q; over_d = over_q; fail_d = fail_q;
    case (cmd_i.op)
      CMD_LOAD: begin
        n_d = n_i; k_d = k_i; b_d = b_i;
      end
      CMD_PRE: begin
        if (nk < k_q) k_d = nk;
        acc_d = W'(1); cur_d = n_q; j_d = W'(1); over_d = 1'b0; fail_d = 1'b0;
      end
      CMD_DIVQ: q_d = dquo;
      CMD_CHKOV: ovf_d = (q_q < acc_q);
      CMD_DIVACC: acc_d = dquo;
      CMD_GCDINIT: begin
        if (acc_q < j_q) begin x_d = j_q; y_d = acc_q; end
        else begin x_d = acc_q; y_d = j_q; end
      end
      // start cycle only launches x % y
      CMD_GCDMOD: begin
        if (!cmd_i.div_start) begin x_d = y_q; y_d = drem; end
      end
      CMD_RED1: jr_d = dquo;
      CMD_RED2: np_d = dquo;
      CMD_RED3: begin
        acc_d = dquo;
        fail_d = (dquo == '0);
      end
      // start cycle only launches MAX / acc
      CMD_MULNP: begin
        if (!cmd_i.div_start) begin
          if (acc_q == '0 || np_q == '0 || dquo < np_q) fail_d = 1'b1;
          else acc_d = prod_q[W-1:0];
        end
      end
      CMD_STEPEND: begin
        cur_d = cur_q - 1'b1;
        j_d = j_q + 1'b1;
        over_d = (acc_q > b_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mph_q <= '0;
    end else begin
      mbusy_q <= mbusy_d;
      mph_q <= mph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; k_q <= k_d; b_q <= b_d; acc_q <= acc_d; cur_q <= cur_d;
    j_q <= j_d; q_q <= q_d; x_q <= x_d; y_q <= y_d; jr_q <= jr_d; np_q <= np_d;
    ovf_q <= ovf_d; over_q <= over_d; fail_q <= fail_d; prod_q <= prod_d;
  end

  assign stat_o.k_gt_n = (k_q > n_q);
  assign stat_o.k_zero = (k_q == '0);
  assign stat_o.bound_zero = (b_q == '0);
  assign stat_o.ovf = ovf_q;
  assign stat_o.gcd_done = (y_q == '0);
  assign stat_o.red_fail = fail_q;
  assign stat_o.over = over_q;
  // j has already been advanced past the step just finished
  assign stat_o.last = (j_q == k_q + W'(1));
  assign stat_o.div_busy = dbusy;
  assign stat_o.mul_busy = mbusy_q;
endmodule
`default_nettype wire

// ----- rtl/bbc_ctrl.sv -----
// Controller: sequences the step loop and the handshakes
`default_nettype none
module bbc_ctrl import bbc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic       exceeds_o,
  output bbc_cmd_t   cmd_o,
  input  wire bbc_stat_t stat_i
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PRE    = 5'd1;
  localparam logic [4:0] S_CHK    = 5'd2;
  localparam logic [4:0] S_OVD    = 5'd3;
  localparam logic [4:0] S_OVQ    = 5'd4;
  localparam logic [4:0] S_OVC    = 5'd5;
  localparam logic [4:0] S_BR     = 5'd6;
  localparam logic [4:0] S_ML     = 5'd7;
  localparam logic [4:0] S_MW     = 5'd8;
  localparam logic [4:0] S_DA     = 5'd9;
  localparam logic [4:0] S_DAW    = 5'd10;
  localparam logic [4:0] S_DAQ    = 5'd11;
  localparam logic [4:0] S_GI     = 5'd12;
  localparam logic [4:0] S_GC     = 5'd13;
  localparam logic [4:0] S_GW     = 5'd14;
  localparam logic [4:0] S_R1     = 5'd15;
  localparam logic [4:0] S_R1W    = 5'd16;
  localparam logic [4:0] S_R2W    = 5'd17;
  localparam logic [4:0] S_R3W    = 5'd18;
  localparam logic [4:0] S_R3C    = 5'd19;
  localparam logic [4:0] S_NPM    = 5'd20;
  localparam logic [4:0] S_NPW    = 5'd21;
  localparam logic [4:0] S_NPC    = 5'd22;
  localparam logic [4:0] S_END    = 5'd23;
  localparam logic [4:0] S_TEST   = 5'd24;
  localparam logic [4:0] S_OUT    = 5'd25;
  localparam logic [4:0] S_GM     = 5'd26;
  localparam logic [4:0] S_R2     = 5'd27;
  localparam logic [4:0] S_R3     = 5'd28;
  localparam logic [4:0] S_NPD    = 5'd29;

  logic [4:0] st_q, st_d;
  logic       res_q, res_d, ov_q, ov_d;

  always_comb begin
    st_d = st_q;
    res_d = res_q;
    ov_d = ov_q;
    cmd_o = '{op: CMD_NONE, div_start: 1'b0};
    unique case (st_q)
      S_IDLE: if (in_valid_i && !(ov_q && out_stall_i)) begin
        cmd_o.op = CMD_LOAD; st_d = S_PRE;
      end
      S_PRE: begin
        if (stat_i.k_gt_n) begin res_d = 1'b0; st_d = S_OUT; end
        else begin cmd_o.op = CMD_PRE; st_d = S_CHK; end
      end
      S_CHK: begin
        if (stat_i.k_zero) begin res_d = stat_i.bound_zero; st_d = S_OUT; end
        else st_d = S_OVD;
      end
      // quotient MAX / cur for the overflow test
      S_OVD: begin cmd_o.div_start = 1'b1; st_d = S_OVQ; end
      S_OVQ: if (!stat_i.div_busy) begin cmd_o.op = CMD_DIVQ; st_d = S_OVC; end
      S_OVC: begin cmd_o.op = CMD_CHKOV; st_d = S_BR; end
      S_BR: st_d = stat_i.ovf ? S_GI : S_ML;
      // no overflow: acc = acc*cur/j
      S_ML: begin cmd_o.op = CMD_MULLO; st_d = S_MW; end
      S_MW: if (!stat_i.mul_busy) st_d = S_DA;
      S_DA: begin cmd_o.op = CMD_DIVACC; cmd_o.div_start = 1'b1; st_d = S_DAW; end
      S_DAW: if (!stat_i.div_busy) st_d = S_DAQ;
      S_DAQ: begin cmd_o.op = CMD_DIVACC; st_d = S_END; end
      // gcd reduction path
      S_GI: begin cmd_o.op = CMD_GCDINIT; st_d = S_GC; end
      S_GC: begin
        if (stat_i.gcd_done) st_d = S_R1;
        else begin cmd_o.op = CMD_GCDMOD; cmd_o.div_start = 1'b1; st_d = S_GW; end
      end
      S_GW: if (!stat_i.div_busy) st_d = S_GM;
      S_GM: begin cmd_o.op = CMD_GCDMOD; st_d = S_GC; end
      S_R1: begin cmd_o.op = CMD_RED1; cmd_o.div_start = 1'b1; st_d = S_R1W; end
      S_R1W: if (!stat_i.div_busy) begin cmd_o.op = CMD_RED1; st_d = S_R2; end
      S_R2: begin cmd_o.op = CMD_RED2; cmd_o.div_start = 1'b1; st_d = S_R2W; end
      S_R2W: if (!stat_i.div_busy) begin cmd_o.op = CMD_RED2; st_d = S_R3; end
      S_R3: begin cmd_o.op = CMD_RED3; cmd_o.div_start = 1'b1; st_d = S_R3W; end
      S_R3W: if (!stat_i.div_busy) begin cmd_o.op = CMD_RED3; st_d = S_R3C; end
      S_R3C: begin
        if (stat_i.red_fail) begin res_d = 1'b1; st_d = S_OUT; end
        else begin cmd_o.op = CMD_MULNP; cmd_o.div_start = 1'b1; st_d = S_NPM; end
      end
      S_NPM: begin cmd_o.op = CMD_MULLO; st_d = S_NPW; end
      S_NPW: if (!stat_i.div_busy && !stat_i.mul_busy) st_d = S_NPC;
      S_NPC: begin cmd_o.op = CMD_MULNP; st_d = S_NPD; end
      S_NPD: begin
        if (stat_i.red_fail) begin res_d = 1'b1; st_d = S_OUT; end
        else st_d = S_END;
      end
      S_END: begin cmd_o.op = CMD_STEPEND; st_d = S_TEST; end
      S_TEST: begin
        if (stat_i.over) begin res_d = 1'b1; st_d = S_OUT; end
        else if (stat_i.last) begin res_d = 1'b0; st_d = S_OUT; end
        else st_d = S_OVD;
      end
      S_OUT: begin ov_d = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
    if (ov_q && !out_stall_i && st_q != S_OUT) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      res_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      res_q <= res_d;
      ov_q <= ov_d;
    end
  end

  assign in_stall_o = !(st_q == S_IDLE) || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;
  assign exceeds_o = res_q;
endmodule
`default_nettype wire

// ----- rtl/bbc_checker.sv -----
// Port-level checker for the binomial bound check, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bbc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic exceeds_o
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_res_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(exceeds_o))
  `ASSERT_IMP(a_one_inflight, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)
  `ASSERT_NEXT(a_take_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind binomial_bound_check_top bbc_checker u_chk (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for binomial_bound_check_top
`default_nettype none
module testbench;
  import bbc_pkg::*;

  localparam int unsigned W = WordBits;
  localparam logic [W-1:0] WMAX = {W{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned N_RANDOM = 215;

  // Scoreboard: predicts the flag for each accepted query, checks results in order
  class flag_scoreboard;
    bit flag_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned true_flags;

    function logic [W-1:0] euclid(logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] t;
      if (x < y) begin
        t = x; x = y; y = t;
      end
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      return x;
    endfunction

    // Walk C(n,j) upward and stop once it passes the bound or leaves the word
    function bit coeff_exceeds(logic [W-1:0] n, logic [W-1:0] k, logic [W-1:0] b);
      logic [W-1:0] acc, cur, j, d, jr, np;
      if (k > n) return 1'b0;
      if (n - k < k) k = n - k;
      if (k == 0) return (b == 0);
      acc = 1;
      cur = n;
      for (j = 1; j <= k; j++) begin
        if (WMAX / cur < acc) begin
          d = euclid(acc, j);
          jr = j / d;
          np = cur / jr;
          acc = acc / d;
          if (acc == 0 || np == 0 || WMAX / acc < np) return 1'b1;
          acc = acc * np;
        end else begin
          acc = (acc * cur) / j;
        end
        cur--;
        if (acc > b) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_query(logic [W-1:0] n, logic [W-1:0] k, logic [W-1:0] b);
      flag_q.push_back(coeff_exceeds(n, k, b));
    endfunction

    function void check_flag(logic actual);
      bit want;
      checked++;
      if (flag_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: exceeds=%b", actual);
        return;
      end
      want = flag_q.pop_front();
      if (want) true_flags++;
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %b, actual %b", checked, want, actual);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, exceeds;
  logic [W-1:0] n_total, k_chosen, limit_value;
  bit sender_idles, recv_stalls;
  int unsigned cycles;
  flag_scoreboard sb;

  binomial_bound_check_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .n_total_i(n_total), .k_chosen_i(k_chosen), .limit_value_i(limit_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .exceeds_o(exceeds)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle count and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: check at the rising edge, pick the next stall at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_flag(exceeds);
      @(negedge clk);
      out_stall = recv_stalls && ($urandom_range(99) < 38);
    end
  end

  // One query transaction, with optional idle cycles first; called at a falling edge
  task automatic send_query(logic [W-1:0] n, logic [W-1:0] k, logic [W-1:0] b);
    while (sender_idles && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    n_total = n;
    k_chosen = k;
    limit_value = b;
    do @(posedge clk); while (in_stall);
    sb.note_query(n, k, b);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Bound spread over many magnitudes so the early stop lands at varied steps
  function automatic logic [W-1:0] rand_bound();
    return rand_word() >> $urandom_range(W - 1);
  endfunction

  initial begin
    logic [W-1:0] n, k;
    sb = new();
    in_valid = 1'b0;
    n_total = '0;
    k_chosen = '0;
    limit_value = '0;
    sender_idles = 1'b1;
    recv_stalls = 1'b1;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: edge values and each special case
    send_query(0, 0, 0);
    send_query(0, 0, 1);
    send_query(5, 6, 0);
    send_query(0, WMAX, 0);
    send_query(WMAX - 1, WMAX, 0);
    send_query(10, 0, 0);
    send_query(10, 10, 0);
    send_query(10, 10, WMAX);
    send_query(WMAX, WMAX, 0);
    send_query(WMAX, 1, WMAX - 1);
    send_query(WMAX, 1, WMAX);
    send_query(WMAX, WMAX - 1, WMAX);
    send_query(WMAX, 2, WMAX);
    send_query(67, 33, WMAX);
    send_query(67, 34, 64'd14226520737620288369);
    send_query(68, 34, WMAX);
    send_query(66, 33, WMAX);
    send_query(62, 31, WMAX);
    send_query(WMAX, W'(1) << 62, WMAX);
    send_query(52, 26, 64'd495918532948104);
    send_query(52, 26, 64'd495918532948103);
    send_query(20, 7, WMAX);
    send_query(1, 1, 0);
    send_query(2, 1, 1);
    send_query(2, 1, 2);

    // Random: mostly small n near the middle, some wide and raw words
    for (int i = 0; i < N_RANDOM; i++) begin
      sender_idles = !(i >= 100 && i < 150);
      recv_stalls = !(i >= 110 && i < 160);
      if (i == 60) begin
        in_valid = 1'b0;
        while (sb.flag_q.size() != 0) @(negedge clk);
      end
      case ($urandom_range(9))
        0, 1: send_query(rand_word(), rand_word(), rand_word());
        2: begin
          n = rand_word() >> $urandom_range(W - 1);
          send_query(n, W'($urandom_range(4)), rand_bound());
        end
        3: begin
          n = rand_word();
          send_query(n, n - W'($urandom_range(3)), rand_bound());
        end
        default: begin
          n = W'($urandom_range(70));
          k = (n / 2) + W'($urandom_range(8)) - W'(4);
          if ($urandom_range(5) == 0) k = W'($urandom_range(72));
          send_query(n, k, ($urandom_range(3) == 0) ? WMAX : rand_bound());
        end
      endcase
    end
    in_valid = 1'b0;

    // Drain remaining results, then allow a quiet tail
    recv_stalls = 1'b1;
    while (sb.flag_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d results (%0d set) over %0d cycles, with idle and stall gaps",
             sb.checked, sb.true_flags, cycles);
    if (sb.mismatches == 0 && sb.flag_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.flag_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
